[hw/rtl/pbtw_pkg.sv]
// ----------------------------------------------------------------------------
// pbtw_pkg
// Shared types and constants of the bit-plane threshold frame store: item
// and result word layouts, mode and status codes, parameter defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package pbtw_pkg;

  localparam int WIDTH_DEF  = 64;
  localparam int HEIGHT_DEF = 32;
  localparam int PLANES_DEF = 4;

  // Width of a row word on the result channel
  localparam int ROW_BITS = 64;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] col;
    logic [7:0] row;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [1:0] plane;
  } in_word_t;

  typedef struct packed {
    logic                status;
    logic [ROW_BITS-1:0] red_bits;
    logic [ROW_BITS-1:0] green_bits;
    logic [ROW_BITS-1:0] blue_bits;
  } out_word_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // take the input word, read its row
    logic commit;   // write back the row, load the result register
  } dp_cmd_t;

endpackage

`default_nettype wire

[hw/rtl/pbtw_ctrl.sv]
// ----------------------------------------------------------------------------
// pbtw_ctrl
// Two-state sequencer: accept a word, then commit it once the result
// register is free. Owns the input ready and output valid handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module pbtw_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output pbtw_pkg::dp_cmd_t     cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   capture;
  logic   commit;

  assign capture = (state_r == ST_IDLE) && in_valid;
  // Commit when the result register is empty or drains this cycle
  assign commit  = (state_r == ST_EXEC) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (capture) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready    = (state_r == ST_IDLE);
  assign out_valid   = out_valid_r;
  assign cmd.capture = capture;
  assign cmd.commit  = commit;

endmodule

`default_nettype wire

[hw/rtl/pbtw_datapath.sv]
// ----------------------------------------------------------------------------
// pbtw_datapath
// Row memories for red, green and blue (all planes of a row in one entry),
// per-row valid bits standing in for the reset clear, threshold update,
// range checks, the blue enable register and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pbtw_datapath #(
  parameter int WIDTH  = pbtw_pkg::WIDTH_DEF,
  parameter int HEIGHT = pbtw_pkg::HEIGHT_DEF,
  parameter int PLANES = pbtw_pkg::PLANES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire pbtw_pkg::dp_cmd_t   cmd,
  input  wire pbtw_pkg::in_word_t  in_data,
  input  wire logic                cfg_valid,
  input  wire logic                cfg_data,
  output pbtw_pkg::out_word_t      out_data
);

  localparam int RW   = (HEIGHT > 1) ? $clog2(HEIGHT) : 1;
  localparam int STEP = 255 / (PLANES + 1);

  typedef logic [PLANES-1:0][WIDTH-1:0] row_t;

  row_t red_mem_r   [HEIGHT];
  row_t green_mem_r [HEIGHT];
  row_t blue_mem_r  [HEIGHT];
  logic [HEIGHT-1:0] vld_r;

  pbtw_pkg::in_word_t  item_r;
  pbtw_pkg::out_word_t out_r;
  row_t                red_rd_r;
  row_t                green_rd_r;
  row_t                blue_rd_r;
  logic                row_vld_r;
  logic                err_r;
  logic                blue_en_r;

  logic          row_ok;
  logic          err_in;
  logic [RW-1:0] rd_addr;
  logic [RW-1:0] wr_addr;
  logic          wr_en;
  logic [WIDTH-1:0] mask;
  row_t red_old;
  row_t green_old;
  row_t blue_old;
  row_t red_new;
  row_t green_new;
  row_t blue_new;
  logic [WIDTH-1:0] red_sel;
  logic [WIDTH-1:0] green_sel;
  logic [WIDTH-1:0] blue_sel;

  // Range checks on the incoming word
  assign row_ok  = (in_data.row < 8'(HEIGHT));
  assign rd_addr = in_data.row[RW-1:0];

  always_comb begin
    if (in_data.mode == pbtw_pkg::MODE_WRITE) begin
      err_in = !row_ok || (in_data.col >= 8'(WIDTH));
    end else begin
      err_in = !row_ok || ({2'b00, in_data.plane} >= 4'(PLANES));
    end
  end

  // Rows never written since reset read as zero
  assign red_old   = row_vld_r ? red_rd_r   : '0;
  assign green_old = row_vld_r ? green_rd_r : '0;
  assign blue_old  = row_vld_r ? blue_rd_r  : '0;

  assign mask = WIDTH'(1) << item_r.col;

  for (genvar p = 0; p < PLANES; p++) begin : g_plane
    localparam logic [7:0] THR = 8'(STEP * (p + 1));

    assign red_new[p]   = (item_r.red > THR) ? (red_old[p] | mask)
                                             : (red_old[p] & ~mask);
    assign green_new[p] = (item_r.green > THR) ? (green_old[p] | mask)
                                               : (green_old[p] & ~mask);
    // Hold blue when disabled
    assign blue_new[p]  = !blue_en_r ? blue_old[p]
                        : (item_r.blue > THR) ? (blue_old[p] | mask)
                                              : (blue_old[p] & ~mask);
  end

  always_comb begin
    red_sel   = '0;
    green_sel = '0;
    blue_sel  = '0;
    for (int p = 0; p < PLANES; p++) begin
      if ({2'b00, item_r.plane} == 4'(p)) begin
        red_sel   = red_old[p];
        green_sel = green_old[p];
        blue_sel  = blue_old[p];
      end
    end
  end

  assign wr_addr = item_r.row[RW-1:0];
  assign wr_en   = cmd.commit && !err_r && (item_r.mode == pbtw_pkg::MODE_WRITE);

  // Memory read at capture, write back at commit
  always_ff @(posedge clk) begin
    if (cmd.capture && row_ok) begin
      red_rd_r   <= red_mem_r[rd_addr];
      green_rd_r <= green_mem_r[rd_addr];
      blue_rd_r  <= blue_mem_r[rd_addr];
    end
    if (wr_en) begin
      red_mem_r[wr_addr]   <= red_new;
      green_mem_r[wr_addr] <= green_new;
      blue_mem_r[wr_addr]  <= blue_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      blue_en_r <= 1'b1;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (cfg_valid) begin
        blue_en_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r    <= in_data;
      err_r     <= err_in;
      row_vld_r <= row_ok && vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_r.status <= err_r ? pbtw_pkg::STATUS_INVALID : pbtw_pkg::STATUS_OK;
      if (!err_r && (item_r.mode == pbtw_pkg::MODE_READ)) begin
        out_r.red_bits   <= pbtw_pkg::ROW_BITS'(red_sel);
        out_r.green_bits <= pbtw_pkg::ROW_BITS'(green_sel);
        out_r.blue_bits  <= pbtw_pkg::ROW_BITS'(blue_sel);
      end else begin
        out_r.red_bits   <= '0;
        out_r.green_bits <= '0;
        out_r.blue_bits  <= '0;
      end
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

[hw/rtl/pixel_bitplane_threshold_writer_top.sv]
// ----------------------------------------------------------------------------
// pixel_bitplane_threshold_writer_top
// At acceptance of a word the addressed row of all three color memories
// is read (one registered read port per memory); once the result register
// is free, the row is modified and written back, or the requested plane
// is selected, and the result register is loaded. The block then accepts
// the next word even while that result waits on out_ready, but takes no
// new word before the current one commits; a result still waiting when
// the following word is ready to commit stretches that commit. After
// reset the store reads as all zeros at once through one valid bit per
// row; there is no clearing pass. blue_enable is written through the cfg
// port, which is always ready, and comes out of reset as 1.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_bitplane_threshold_writer_top #(
  parameter int WIDTH  = pbtw_pkg::WIDTH_DEF,
  parameter int HEIGHT = pbtw_pkg::HEIGHT_DEF,
  parameter int PLANES = pbtw_pkg::PLANES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire pbtw_pkg::in_word_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output pbtw_pkg::out_word_t      out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic                cfg_data
);

  pbtw_pkg::dp_cmd_t cmd;

  assign cfg_ready = 1'b1;

  pbtw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  pbtw_datapath #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT),
    .PLANES (PLANES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

[hw/rtl/pbtw_checker.sv]
// ----------------------------------------------------------------------------
// pbtw_checker
// Port-level checks of the frame store: handshake hold, one word in flight,
// result timing and write result contents. Bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pbtw_checker #(
  parameter int WIDTH  = pbtw_pkg::WIDTH_DEF,
  parameter int HEIGHT = pbtw_pkg::HEIGHT_DEF
) (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire pbtw_pkg::in_word_t  in_data,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire pbtw_pkg::out_word_t out_data
);

  logic in_acc;
  logic out_free;
  logic wr_acc;

  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign wr_acc   = in_acc && out_free && (in_data.mode == pbtw_pkg::MODE_WRITE);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("word accepted while another is in flight");

  a_result_timing: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && out_free |-> ##2 out_valid)
    else $error("result missing two cycles after acceptance");

  a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    wr_acc |-> ##2 (out_data.red_bits == '0 && out_data.green_bits == '0 &&
                    out_data.blue_bits == '0))
    else $error("write result carries row bits");

  a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_acc && (in_data.col >= 8'(WIDTH) || in_data.row >= 8'(HEIGHT))
      |-> ##2 (out_data.status == pbtw_pkg::STATUS_INVALID))
    else $error("out-of-range write not flagged");

endmodule

bind pixel_bitplane_threshold_writer_top pbtw_checker #(
  .WIDTH  (WIDTH),
  .HEIGHT (HEIGHT)
) u_pbtw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// Bit-plane threshold frame store testbench
// Drives pixel writes and plane row reads through the valid/ready channels,
// switches blue_enable between phases, and checks every result word against
// a scoreboard that keeps its own copy of the red, green and blue planes.
// ----------------------------------------------------------------------------

class bitplane_scoreboard;
  localparam int N_COLS     = pbtw_pkg::WIDTH_DEF;
  localparam int N_ROWS     = pbtw_pkg::HEIGHT_DEF;
  localparam int N_PLANES   = pbtw_pkg::PLANES_DEF;
  localparam int LEVEL_STEP = 255 / (N_PLANES + 1);

  logic [63:0] red_rows   [N_PLANES][N_ROWS];
  logic [63:0] green_rows [N_PLANES][N_ROWS];
  logic [63:0] blue_rows  [N_PLANES][N_ROWS];
  bit          blue_en;

  pbtw_pkg::out_word_t expected_words[$];

  int errors;
  int n_writes;
  int n_reads;
  int n_invalid;
  int n_checked;

  function new();
    foreach (red_rows[p, r]) begin
      red_rows[p][r]   = '0;
      green_rows[p][r] = '0;
      blue_rows[p][r]  = '0;
    end
    blue_en = 1'b1;
  endfunction

  function int pending();
    return expected_words.size();
  endfunction

  // Set or clear the pixel bit depending on the level against this plane's threshold
  function logic [63:0] threshold_bit(logic [63:0] row_word, logic [63:0] mask,
                                      logic [7:0] level, int plane_idx);
    if (int'(level) > LEVEL_STEP * (plane_idx + 1)) begin
      return row_word | mask;
    end
    return row_word & ~mask;
  endfunction

  function void note_word(pbtw_pkg::in_word_t w);
    pbtw_pkg::out_word_t res;
    logic [63:0] mask;
    res = '0;
    if (w.mode == pbtw_pkg::MODE_WRITE) begin
      n_writes++;
      if (w.col >= N_COLS || w.row >= N_ROWS) begin
        res.status = pbtw_pkg::STATUS_INVALID;
        n_invalid++;
      end else begin
        mask = 64'd1 << w.col[5:0];
        for (int p = 0; p < N_PLANES; p++) begin
          red_rows[p][w.row]   = threshold_bit(red_rows[p][w.row], mask, w.red, p);
          green_rows[p][w.row] = threshold_bit(green_rows[p][w.row], mask, w.green, p);
          if (blue_en) begin
            blue_rows[p][w.row] = threshold_bit(blue_rows[p][w.row], mask, w.blue, p);
          end
        end
        res.status = pbtw_pkg::STATUS_OK;
      end
    end else begin
      n_reads++;
      if (w.row >= N_ROWS || w.plane >= N_PLANES) begin
        res.status = pbtw_pkg::STATUS_INVALID;
        n_invalid++;
      end else begin
        res.status     = pbtw_pkg::STATUS_OK;
        res.red_bits   = red_rows[w.plane][w.row];
        res.green_bits = green_rows[w.plane][w.row];
        res.blue_bits  = blue_rows[w.plane][w.row];
      end
    end
    expected_words.push_back(res);
  endfunction

  function void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %h, actual %h", name, want, got);
      errors++;
    end
  endfunction

  function void check_word(pbtw_pkg::out_word_t got);
    pbtw_pkg::out_word_t want;
    if (expected_words.size() == 0) begin
      $error("result word with nothing expected: %h", got);
      errors++;
      return;
    end
    want = expected_words.pop_front();
    n_checked++;
    check_field("status", 64'(want.status), 64'(got.status));
    check_field("red_bits", want.red_bits, got.red_bits);
    check_field("green_bits", want.green_bits, got.green_bits);
    check_field("blue_bits", want.blue_bits, got.blue_bits);
  endfunction
endclass

module testbench;
  localparam int N_COLS       = pbtw_pkg::WIDTH_DEF;
  localparam int N_ROWS       = pbtw_pkg::HEIGHT_DEF;
  localparam int N_PLANES     = pbtw_pkg::PLANES_DEF;
  localparam int LEVEL_STEP   = 255 / (N_PLANES + 1);
  localparam int N_PHASES     = 5;
  localparam int PHASE_WORDS  = 340;
  localparam int QUIET_AT     = 140;
  localparam int HOLD_AFTER   = 500;
  localparam int HOLD_CYCLES  = 120;
  localparam int STALL_LIMIT  = 1000;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  pbtw_pkg::in_word_t  in_data;
  logic                out_valid;
  logic                out_ready;
  pbtw_pkg::out_word_t out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic                cfg_data;

  bitplane_scoreboard sb;
  bit                 quiet;
  bit                 hold_done;
  int                 idle_cycles;

  pixel_bitplane_threshold_writer_top #(
    .WIDTH (N_COLS),
    .HEIGHT(N_ROWS),
    .PLANES(N_PLANES)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic pbtw_pkg::in_word_t make_word(logic mode, int col, int row,
                                                   int r, int g, int b, int plane);
    pbtw_pkg::in_word_t w;
    w.mode  = mode;
    w.col   = 8'(col);
    w.row   = 8'(row);
    w.red   = 8'(r);
    w.green = 8'(g);
    w.blue  = 8'(b);
    w.plane = 2'(plane);
    return w;
  endfunction

  // Favor levels right at a plane threshold, then the extremes
  function automatic logic [7:0] pick_level();
    int sel;
    int k;
    sel = $urandom_range(0, 9);
    k   = $urandom_range(1, N_PLANES);
    if (sel < 3) begin
      return 8'(k * LEVEL_STEP + int'($urandom_range(0, 2)) - 1);
    end
    if (sel == 3) begin
      return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic pbtw_pkg::in_word_t random_word();
    pbtw_pkg::in_word_t w;
    int sel;
    w.mode = ($urandom_range(0, 99) < 55) ? pbtw_pkg::MODE_WRITE : pbtw_pkg::MODE_READ;
    w.col  = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(0, N_COLS - 1));
    sel = $urandom_range(0, 9);
    if (sel < 5) begin
      // crowd a few rows so reads see many bits
      w.row = 8'($urandom_range(0, 7));
    end else if (sel < 9) begin
      w.row = 8'($urandom_range(0, N_ROWS - 1));
    end else begin
      w.row = 8'($urandom_range(0, 255));
    end
    w.red   = pick_level();
    w.green = pick_level();
    w.blue  = pick_level();
    w.plane = 2'($urandom_range(0, 3));
    return w;
  endfunction

  function automatic int pick_gap();
    if (quiet || $urandom_range(0, 3) != 0) begin
      return 0;
    end
    return $urandom_range(1, 8);
  endfunction

  task automatic send_word(input pbtw_pkg::in_word_t w, input int gap);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    sb.note_word(w);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic set_blue_enable(input logic en);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= en;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.blue_en = en;
  endtask

  task automatic run_directed();
    // thresholds sit at 51, 102, 153, 204: hit each from both sides
    send_word(make_word(pbtw_pkg::MODE_WRITE, 0, 0, 255, 0, 255, 0), pick_gap());
    send_word(make_word(pbtw_pkg::MODE_WRITE, N_COLS - 1, N_ROWS - 1, 52, 51, 103, 3),
              pick_gap());
    send_word(make_word(pbtw_pkg::MODE_WRITE, 1, 0, 102, 103, 153, 1), pick_gap());
    send_word(make_word(pbtw_pkg::MODE_WRITE, 2, 0, 154, 204, 205, 2), pick_gap());
    send_word(make_word(pbtw_pkg::MODE_WRITE, N_COLS - 1, 0, 0, 255, 0, 3), pick_gap());
    // out of range writes leave the store alone
    send_word(make_word(pbtw_pkg::MODE_WRITE, N_COLS, 0, 255, 255, 255, 0), pick_gap());
    send_word(make_word(pbtw_pkg::MODE_WRITE, 255, 255, 255, 255, 255, 3), pick_gap());
    send_word(make_word(pbtw_pkg::MODE_WRITE, 0, N_ROWS, 255, 255, 255, 0), pick_gap());
    for (int p = 0; p < N_PLANES; p++) begin
      send_word(make_word(pbtw_pkg::MODE_READ, 255, 0, 255, 255, 255, p), pick_gap());
    end
    send_word(make_word(pbtw_pkg::MODE_READ, 0, N_ROWS - 1, 0, 0, 0, N_PLANES - 1),
              pick_gap());
    send_word(make_word(pbtw_pkg::MODE_READ, 0, N_ROWS, 0, 0, 0, 0), pick_gap());
    send_word(make_word(pbtw_pkg::MODE_READ, 0, 255, 0, 0, 0, 0), pick_gap());
    send_word(make_word(pbtw_pkg::MODE_WRITE, 0, 0, 0, 0, 0, 0), pick_gap());
    send_word(make_word(pbtw_pkg::MODE_READ, 0, 0, 0, 0, 0, 0), pick_gap());
    // blue planes keep their bits while disabled
    set_blue_enable(1'b0);
    send_word(make_word(pbtw_pkg::MODE_WRITE, 0, 0, 255, 255, 0, 0), pick_gap());
    send_word(make_word(pbtw_pkg::MODE_WRITE, N_COLS - 1, N_ROWS - 1, 0, 0, 255, 0),
              pick_gap());
    send_word(make_word(pbtw_pkg::MODE_READ, 0, 0, 0, 0, 0, 0), pick_gap());
    send_word(make_word(pbtw_pkg::MODE_READ, 0, N_ROWS - 1, 0, 0, 0, 0), pick_gap());
  endtask

  // result side: random stall bursts plus one long hold-off to back up the block
  initial begin
    int gap;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (!quiet && !hold_done && sb.n_checked >= HOLD_AFTER) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 8);
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      if (out_valid && out_ready) begin
        sb.check_word(out_data);
      end
    end
  end

  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if (rst_n) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        begin
          idle_cycles = 0;
        end else begin
          idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
          $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
          $display("pixel_bitplane_threshold_writer_top test failed");
          $finish;
        end
      end
    end
  end

  initial begin
    sb        = new();
    quiet     = 1'b0;
    hold_done = 1'b0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    for (int ph = 0; ph < N_PHASES; ph++) begin
      set_blue_enable((ph % 2 == 0) ? 1'b1 : 1'b0);
      for (int k = 0; k < PHASE_WORDS; k++) begin
        if (ph == N_PHASES - 1 && k == QUIET_AT) begin
          quiet = 1'b1;
        end
        send_word(random_word(), pick_gap());
      end
    end

    drain();
    repeat (8) @(posedge clk);
    $display("covered %0d pixel writes and %0d plane reads (%0d out of range),",
             sb.n_writes, sb.n_reads, sb.n_invalid);
    $display("blue_enable toggled between 0 and 1; %0d result words checked", sb.n_checked);
    if (sb.errors == 0) begin
      $display("pixel_bitplane_threshold_writer_top test passed");
    end else begin
      $display("pixel_bitplane_threshold_writer_top test failed");
    end
    $finish;
  end
endmodule
